// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, idle while reset is low
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Same-cycle implication on the rising clock edge, idle while reset is low
`define ASSERT_IMPL(label, clk_sig, rst_n_sig, cond, expr, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (cond) |-> (expr)) \
		else $error(msg);

`endif

// ===== sv/rthc_pkg.sv =====
// Types, constants and divider step function for the RGB to HSB converter
package rthc_pkg;

	localparam int CH_W       = 8;
	localparam int FRAC_W     = 16;
	localparam int DEN_W      = 11;
	localparam int Q_PER_STG  = 2;
	localparam int DIV_STAGES = FRAC_W / Q_PER_STG;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [FRAC_W-1:0] hue_turn;
		logic [FRAC_W-1:0] sat_frac;
		logic [CH_W-1:0]   bright_level;
	} hsb_t;

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

	typedef struct packed {
		logic [Q_PER_STG-1:0] q;
		logic [DEN_W-1:0]     rem;
	} div_step_t;

	// Two restoring division steps; rem must be below den on entry
	function automatic div_step_t div_step(input logic [DEN_W-1:0] rem,
			input logic [DEN_W-1:0] den);
		logic [DEN_W:0]   t;
		logic [DEN_W-1:0] r;
		div_step_t        res;
		r = rem;
		res.q = '0;
		for (int i = 0; i < Q_PER_STG; i++) begin
			t = {r, 1'b0};
			if (t >= {1'b0, den}) begin
				res.q[Q_PER_STG-1-i] = 1'b1;
				t = t - {1'b0, den};
			end
			r = t[DEN_W-1:0];
		end
		res.rem = r;
		return res;
	endfunction

endpackage

// ===== sv/rgb_to_hsb_convert_unit.sv =====
// RGB to hue/saturation/brightness converter, fully pipelined
// An accepted pixel passes through stage 1, stage 2 and the divider stages to its result on hsb.
// Throughput: one pixel per cycle while no result is stalled; two front stages find max, min and the
// hue numerator, then eight stages each retire two quotient bits of both dividers.
// A stalled result freezes the whole pipe; pix_stall follows hsb_stall while a result waits.
// Reset clears the valid bits only; data registers are left as they are.
module rgb_to_hsb_convert_unit
	import rthc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  pix_t pix,
	output logic hsb_valid,
	input  logic hsb_stall,
	output hsb_t hsb
);

	logic adv;

	// stage 1: max, min and which channel wins
	logic            vld_s1;
	logic [CH_W-1:0] r_s1, g_s1, b_s1, vmax_s1, vmin_s1;
	max_sel_t        sel_s1;

	// stage 2: numerators and denominators
	logic             vld_s2;
	logic [DEN_W-1:0] hnum_s2, hden_s2;
	logic [CH_W-1:0]  snum_s2, sden_s2;
	logic             zero_s2, full_s2;

	// divider stages
	logic              vld_sd   [DIV_STAGES];
	logic [DEN_W-1:0]  hrem_sd  [DIV_STAGES];
	logic [DEN_W-1:0]  hden_sd  [DIV_STAGES];
	logic [FRAC_W-1:0] hq_sd    [DIV_STAGES];
	logic [CH_W-1:0]   srem_sd  [DIV_STAGES];
	logic [CH_W-1:0]   sden_sd  [DIV_STAGES];
	logic [FRAC_W-1:0] sq_sd    [DIV_STAGES];
	logic              zero_sd  [DIV_STAGES];
	logic              full_sd  [DIV_STAGES];
	logic [CH_W-1:0]   bright_sd[DIV_STAGES];

	logic [CH_W-1:0] mx_rg, mn_rg, vmax_c, vmin_c;
	max_sel_t        sel_c;

	logic [CH_W-1:0]  d_c;
	logic [DEN_W-1:0] d_w, den_c, num_c;

	// hold everything while the finished item waits
	assign adv       = !(vld_sd[DIV_STAGES-1] && hsb_stall);
	assign pix_stall = !adv;

	always_comb begin
		mx_rg  = (pix.red_in > pix.green_in) ? pix.red_in : pix.green_in;
		mn_rg  = (pix.red_in < pix.green_in) ? pix.red_in : pix.green_in;
		vmax_c = (mx_rg > pix.blue_in) ? mx_rg : pix.blue_in;
		vmin_c = (mn_rg < pix.blue_in) ? mn_rg : pix.blue_in;
		// ties go to red, then green
		priority if (pix.red_in >= pix.green_in && pix.red_in >= pix.blue_in)
			sel_c = SEL_RED;
		else if (pix.green_in >= pix.blue_in)
			sel_c = SEL_GREEN;
		else
			sel_c = SEL_BLUE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1    <= pix.red_in;
			g_s1    <= pix.green_in;
			b_s1    <= pix.blue_in;
			vmax_s1 <= vmax_c;
			vmin_s1 <= vmin_c;
			sel_s1  <= sel_c;
		end
	end

	always_comb begin
		d_c   = vmax_s1 - vmin_s1;
		d_w   = {{(DEN_W-CH_W){1'b0}}, d_c};
		den_c = (d_w << 2) + (d_w << 1);
		unique case (sel_s1)
			SEL_RED: begin
				// wrap a negative hue by one full turn
				if (g_s1 >= b_s1)
					num_c = {{(DEN_W-CH_W){1'b0}}, g_s1 - b_s1};
				else
					num_c = den_c - {{(DEN_W-CH_W){1'b0}}, b_s1 - g_s1};
			end
			SEL_GREEN: num_c = (d_w << 1) + {{(DEN_W-CH_W){1'b0}}, b_s1}
					- {{(DEN_W-CH_W){1'b0}}, r_s1};
			SEL_BLUE:  num_c = (d_w << 2) + {{(DEN_W-CH_W){1'b0}}, r_s1}
					- {{(DEN_W-CH_W){1'b0}}, g_s1};
			default:   num_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hnum_s2 <= num_c;
			hden_s2 <= den_c;
			snum_s2 <= d_c;
			sden_s2 <= vmax_s1;
			zero_s2 <= (d_c == '0);
			full_s2 <= (vmin_s1 == '0);
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [DEN_W-1:0]  hrem_in, hden_in;
		logic [FRAC_W-1:0] hq_in, sq_in;
		logic [CH_W-1:0]   srem_in, sden_in, bright_in;
		logic              vld_in, zero_in, full_in;
		div_step_t         hstep, sstep;

		if (k == 0) begin : g_first
			// a full-scale saturation divides zero, it is forced at the end
			assign vld_in    = vld_s2;
			assign hrem_in   = hnum_s2;
			assign hden_in   = hden_s2;
			assign hq_in     = '0;
			assign srem_in   = full_s2 ? '0 : snum_s2;
			assign sden_in   = sden_s2;
			assign sq_in     = '0;
			assign zero_in   = zero_s2;
			assign full_in   = full_s2;
			assign bright_in = sden_s2;
		end else begin : g_next
			assign vld_in    = vld_sd[k-1];
			assign hrem_in   = hrem_sd[k-1];
			assign hden_in   = hden_sd[k-1];
			assign hq_in     = hq_sd[k-1];
			assign srem_in   = srem_sd[k-1];
			assign sden_in   = sden_sd[k-1];
			assign sq_in     = sq_sd[k-1];
			assign zero_in   = zero_sd[k-1];
			assign full_in   = full_sd[k-1];
			assign bright_in = bright_sd[k-1];
		end

		assign hstep = div_step(hrem_in, hden_in);
		assign sstep = div_step({{(DEN_W-CH_W){1'b0}}, srem_in},
				{{(DEN_W-CH_W){1'b0}}, sden_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[k] <= 1'b0;
			end else if (adv) begin
				vld_sd[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				hrem_sd[k]   <= hstep.rem;
				hden_sd[k]   <= hden_in;
				hq_sd[k]     <= {hq_in[FRAC_W-Q_PER_STG-1:0], hstep.q};
				srem_sd[k]   <= sstep.rem[CH_W-1:0];
				sden_sd[k]   <= sden_in;
				sq_sd[k]     <= {sq_in[FRAC_W-Q_PER_STG-1:0], sstep.q};
				zero_sd[k]   <= zero_in;
				full_sd[k]   <= full_in;
				bright_sd[k] <= bright_in;
			end
		end
	end

	always_comb begin
		hsb_valid        = vld_sd[DIV_STAGES-1];
		hsb.bright_level = bright_sd[DIV_STAGES-1];
		priority if (zero_sd[DIV_STAGES-1]) begin
			hsb.hue_turn = '0;
			hsb.sat_frac = '0;
		end else if (full_sd[DIV_STAGES-1]) begin
			hsb.hue_turn = hq_sd[DIV_STAGES-1];
			hsb.sat_frac = '1;
		end else begin
			hsb.hue_turn = hq_sd[DIV_STAGES-1];
			hsb.sat_frac = sq_sd[DIV_STAGES-1];
		end
	end

endmodule

// ===== sv/rthc_checker.sv =====
// Port-level checker for the RGB to HSB converter and its bind
`include "assert_macros.svh"

module rthc_checker
	import rthc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_stall,
	input pix_t pix,
	input logic hsb_valid,
	input logic hsb_stall,
	input hsb_t hsb
);

	// a stalled result stays put
	`ASSERT_CLK(a_hsb_hold, clk, arst_n, hsb_valid && hsb_stall |=> hsb_valid && $stable(hsb), "stalled result changed")

	// the input side only waits on a blocked result
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, pix_stall, hsb_valid && hsb_stall, "input stalled with no blocked result")

	// black gives no hue and no saturation
	`ASSERT_IMPL(a_black, clk, arst_n, hsb_valid && hsb.bright_level == '0, hsb.hue_turn == '0 && hsb.sat_frac == '0, "black pixel with hue or saturation")

	// zero saturation only for grey, which has no hue
	`ASSERT_IMPL(a_grey_hue, clk, arst_n, hsb_valid && hsb.sat_frac == '0, hsb.hue_turn == '0, "grey pixel with hue")

endmodule

bind rgb_to_hsb_convert_unit rthc_checker u_rthc_checker (.*);
